// ===== rtl/fcc_pkg.sv =====
package fcc_pkg;

  localparam int CHUNK_BYTES_DEFAULT = 50;
  localparam logic [7:0] PORT_COMMAND_RESET = 8'h01;

  localparam logic [7:0] HEADER_FIRST = 8'h55;
  localparam logic [7:0] HEADER_SECOND = 8'hAA;

  // Chunk offsets with a fixed meaning.
  localparam logic [7:0] OFS_HEADER_FIRST = 8'd0;
  localparam logic [7:0] OFS_HEADER_SECOND = 8'd1;
  localparam logic [7:0] OFS_COMMAND = 8'd2;
  localparam logic [7:0] OFS_LENGTH = 8'd3;
  localparam logic [7:0] OFS_BYTE_FOUR = 8'd4;
  localparam logic [7:0] OFS_BYTE_FIVE = 8'd5;
  localparam logic [7:0] OFS_MAX = 8'd255;

  // Header, command, length and two check bytes around the payload.
  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [8:0] FIRST_CHECK_OFS = 9'd4;
  localparam logic [8:0] SECOND_CHECK_OFS = 9'd5;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RUN,
    PH_BADHDR,
    PH_OVERSIZE,
    PH_BADCHECK,
    PH_OK
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BADHDR = 3'd1,
    ST_BADCHECK = 3'd2,
    ST_SHORT = 3'd3,
    ST_OVERSIZE = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic chunk_first;
    logic chunk_last;
  } in_beat_t;

  typedef struct packed {
    status_t status;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic port_valid;
    logic [15:0] port;
  } result_t;

endpackage

// ===== rtl/fcc_in_stage.sv =====
module fcc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  fcc_pkg::in_beat_t s_beat,
  output logic              stage_valid,
  output fcc_pkg::in_beat_t stage_beat,
  input  logic              stage_take
);

  // The stage is free again in the same cycle its beat is consumed.
  assign s_tready = !stage_valid || stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_beat <= s_beat;
    end
  end

endmodule

// ===== rtl/fcc_core.sv =====
module fcc_core #(
  parameter int CHUNK_BYTES = fcc_pkg::CHUNK_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              stage_valid,
  input  fcc_pkg::in_beat_t stage_beat,
  output logic              stage_take,
  output logic              res_valid,
  output fcc_pkg::result_t  res,
  input  logic              res_ready
);

  localparam logic [8:0] CHUNK_LIMIT = 9'(CHUNK_BYTES);

  logic [7:0] port_command;

  fcc_pkg::phase_t phase;
  logic [7:0] sum_low;
  logic [7:0] sum_high;
  logic [7:0] bytes_left;
  logic [7:0] command_held;
  logic [7:0] length_held;
  logic [7:0] byte_four;
  logic [7:0] byte_five;
  logic [7:0] chunk_offset;

  // Values after the start-of-chunk clear and the byte update.
  fcc_pkg::phase_t phase_mid;
  logic [7:0] sum_low_mid;
  logic [7:0] sum_high_mid;
  logic [7:0] bytes_left_mid;
  logic [7:0] command_mid;
  logic [7:0] length_mid;
  logic [7:0] byte_four_mid;
  logic [7:0] byte_five_mid;
  logic [7:0] offset_mid;
  logic       active;

  fcc_pkg::phase_t phase_next;
  logic [7:0] chunk_offset_next;

  logic            emit;
  fcc_pkg::result_t res_next;

  assign stage_take = stage_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      port_command <= fcc_pkg::PORT_COMMAND_RESET;
    end else if (cfg_we) begin
      port_command <= cfg_wdata;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [8:0] len_ext;
    logic [8:0] ofs_ext;
    b = stage_beat.data_byte;
    if (stage_beat.chunk_first) begin
      phase_mid = fcc_pkg::PH_RUN;
      sum_low_mid = '0;
      sum_high_mid = '0;
      bytes_left_mid = '0;
      command_mid = '0;
      length_mid = '0;
      byte_four_mid = '0;
      byte_five_mid = '0;
      offset_mid = '0;
    end else begin
      phase_mid = phase;
      sum_low_mid = sum_low;
      sum_high_mid = sum_high;
      bytes_left_mid = bytes_left;
      command_mid = command_held;
      length_mid = length_held;
      byte_four_mid = byte_four;
      byte_five_mid = byte_five;
      offset_mid = chunk_offset;
    end
    active = (phase_mid != fcc_pkg::PH_IDLE);
    len_ext = {1'b0, length_mid};
    ofs_ext = {1'b0, offset_mid};

    if (active) begin
      if (offset_mid == fcc_pkg::OFS_COMMAND) command_mid = b;
      if (offset_mid == fcc_pkg::OFS_LENGTH) length_mid = b;
      if (offset_mid == fcc_pkg::OFS_BYTE_FOUR) byte_four_mid = b;
      if (offset_mid == fcc_pkg::OFS_BYTE_FIVE) byte_five_mid = b;
    end

    if (active && phase_mid == fcc_pkg::PH_RUN) begin
      if (offset_mid == fcc_pkg::OFS_HEADER_FIRST) begin
        if (b != fcc_pkg::HEADER_FIRST) phase_mid = fcc_pkg::PH_BADHDR;
      end else if (offset_mid == fcc_pkg::OFS_HEADER_SECOND) begin
        if (b != fcc_pkg::HEADER_SECOND) phase_mid = fcc_pkg::PH_BADHDR;
      end else if (offset_mid == fcc_pkg::OFS_COMMAND) begin
        sum_low_mid = b;
        sum_high_mid = b;
      end else if (offset_mid == fcc_pkg::OFS_LENGTH) begin
        if ({1'b0, b} + fcc_pkg::FRAME_OVERHEAD > CHUNK_LIMIT) begin
          phase_mid = fcc_pkg::PH_OVERSIZE;
        end else begin
          sum_low_mid = sum_low_mid + b;
          sum_high_mid = sum_high_mid + sum_low_mid;
          bytes_left_mid = b;
        end
      end else if (bytes_left_mid != '0) begin
        sum_low_mid = sum_low_mid + b;
        sum_high_mid = sum_high_mid + sum_low_mid;
        bytes_left_mid = bytes_left_mid - 8'd1;
      end else if (ofs_ext == len_ext + fcc_pkg::FIRST_CHECK_OFS) begin
        if (b != sum_low_mid) phase_mid = fcc_pkg::PH_BADCHECK;
      end else if (ofs_ext == len_ext + fcc_pkg::SECOND_CHECK_OFS) begin
        phase_mid = (b != sum_high_mid) ? fcc_pkg::PH_BADCHECK : fcc_pkg::PH_OK;
      end
    end
  end

  // Next state: a reported chunk returns to idle, otherwise the offset moves on.
  always_comb begin
    phase_next = phase_mid;
    chunk_offset_next = offset_mid;
    if (emit) begin
      phase_next = fcc_pkg::PH_IDLE;
    end else if (active && offset_mid != fcc_pkg::OFS_MAX) begin
      chunk_offset_next = offset_mid + 8'd1;
    end
  end

  // A verdict is held back until chunk byte 5 so that short chunks always win.
  always_comb begin
    logic verdict;
    fcc_pkg::status_t st;
    verdict = active && (phase_mid == fcc_pkg::PH_BADHDR ||
                         phase_mid == fcc_pkg::PH_OVERSIZE ||
                         phase_mid == fcc_pkg::PH_BADCHECK ||
                         phase_mid == fcc_pkg::PH_OK) &&
              (offset_mid >= fcc_pkg::OFS_BYTE_FIVE);
    emit = active && (verdict || stage_beat.chunk_last);
    case (phase_mid)
      fcc_pkg::PH_BADHDR:   st = fcc_pkg::ST_BADHDR;
      fcc_pkg::PH_OVERSIZE: st = fcc_pkg::ST_OVERSIZE;
      fcc_pkg::PH_BADCHECK: st = fcc_pkg::ST_BADCHECK;
      default:              st = fcc_pkg::ST_OK;
    endcase
    if (!verdict) st = fcc_pkg::ST_SHORT;
    res_next.status = st;
    res_next.command = command_mid;
    res_next.payload_length = length_mid;
    res_next.port_valid = (st == fcc_pkg::ST_OK) && (command_mid == port_command);
    res_next.port = res_next.port_valid ? {byte_five_mid, byte_four_mid} : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= fcc_pkg::PH_IDLE;
      sum_low <= '0;
      sum_high <= '0;
      bytes_left <= '0;
      command_held <= '0;
      length_held <= '0;
      byte_four <= '0;
      byte_five <= '0;
      chunk_offset <= '0;
    end else if (stage_take) begin
      phase <= phase_next;
      sum_low <= sum_low_mid;
      sum_high <= sum_high_mid;
      bytes_left <= bytes_left_mid;
      command_held <= command_mid;
      length_held <= length_mid;
      byte_four <= byte_four_mid;
      byte_five <= byte_five_mid;
      chunk_offset <= chunk_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stage_take) begin
      res_valid <= emit;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_take && emit) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/framed_command_checker.sv =====
// Checks command frames carried at the start of received chunks, one byte per
// beat. A chunk opens with a beat that has tuser set and closes with tlast; its
// frame is 0x55 0xAA, command, length, payload, then two Fletcher-style check
// bytes over command, length and payload. Each chunk that reaches a verdict or
// closes with tlast gives one result beat with status, command, length and, for
// a valid frame whose command matches the configured port command, the little-endian
// port from chunk bytes 4 and 5. Bytes seen outside a chunk are ignored. A byte is
// accepted every cycle while the result side is not stalled; its result, if it makes
// one, passes the input register, then the per-byte state update into the result
// register, the update being two chained 8-bit adds or a compare on the running sums.
// port_command may be written only while no chunk is in flight.
module framed_command_checker #(
  parameter int CHUNK_BYTES = fcc_pkg::CHUNK_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] chunk_first
  input  logic        s_tlast,   // chunk_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [2:0] status, [10:3] command,
                                 // [18:11] payload_length, [34:19] port, rest zero
  output logic        m_tuser    // [0] port_valid
);

  fcc_pkg::in_beat_t s_beat;
  fcc_pkg::in_beat_t stage_beat;
  logic              stage_valid;
  logic              stage_take;
  fcc_pkg::result_t  res;

  assign s_beat.data_byte = s_tdata;
  assign s_beat.chunk_first = s_tuser;
  assign s_beat.chunk_last = s_tlast;

  fcc_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_beat      (s_beat),
    .stage_valid (stage_valid),
    .stage_beat  (stage_beat),
    .stage_take  (stage_take)
  );

  fcc_core #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .stage_valid (stage_valid),
    .stage_beat  (stage_beat),
    .stage_take  (stage_take),
    .res_valid   (m_tvalid),
    .res         (res),
    .res_ready   (m_tready)
  );

  assign m_tdata = {5'd0, res.port, res.payload_length, res.command, res.status};
  assign m_tuser = res.port_valid;

endmodule

// ===== sim/fcc_frame_monitor.sv =====
`timescale 1ns / 100ps

module fcc_frame_monitor #(
  parameter int CHUNK_BYTES = fcc_pkg::CHUNK_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  output int          fail_count,
  output int          expected_count
);
  import fcc_pkg::*;

  phase_t     phase;
  logic [7:0] sum_lo;
  logic [7:0] sum_hi;
  logic [7:0] bytes_left;
  logic [7:0] cmd_held;
  logic [7:0] len_held;
  logic [7:0] byte4;
  logic [7:0] byte5;
  logic [7:0] ofs;
  logic [7:0] port_cmd;
  result_t    verdicts_due[$];

  task automatic clear_frame();
    sum_lo = '0;
    sum_hi = '0;
    bytes_left = '0;
    cmd_held = '0;
    len_held = '0;
    byte4 = '0;
    byte5 = '0;
    ofs = '0;
  endtask

  task automatic close_frame(input status_t st, output result_t res);
    res.status = st;
    res.command = cmd_held;
    res.payload_length = len_held;
    res.port_valid = (st == ST_OK) && (cmd_held == port_cmd);
    res.port = res.port_valid ? {byte5, byte4} : 16'h0000;
    phase = PH_IDLE;
  endtask

  // Advances the frame state by one accepted byte and reports whether the
  // byte closes the chunk with a result, either a verdict or short.
  task automatic advance_frame(input logic [7:0] b, input logic beat_first,
                               input logic beat_last, output logic emitted,
                               output result_t res);
    logic [8:0] ofs9;
    logic [8:0] len9;
    status_t    st;
    emitted = 1'b0;
    res = '0;
    if (beat_first) begin
      clear_frame();
      phase = PH_RUN;
    end
    if (phase == PH_IDLE) return;

    ofs9 = {1'b0, ofs};
    len9 = {1'b0, len_held};
    if (ofs == OFS_COMMAND) cmd_held = b;
    if (ofs == OFS_LENGTH) len_held = b;
    if (ofs == OFS_BYTE_FOUR) byte4 = b;
    if (ofs == OFS_BYTE_FIVE) byte5 = b;

    if (phase == PH_RUN) begin
      if (ofs == OFS_HEADER_FIRST) begin
        if (b != HEADER_FIRST) phase = PH_BADHDR;
      end else if (ofs == OFS_HEADER_SECOND) begin
        if (b != HEADER_SECOND) phase = PH_BADHDR;
      end else if (ofs == OFS_COMMAND) begin
        sum_lo = b;
        sum_hi = b;
      end else if (ofs == OFS_LENGTH) begin
        if ({1'b0, b} + FRAME_OVERHEAD > CHUNK_BYTES) begin
          phase = PH_OVERSIZE;
        end else begin
          sum_lo = sum_lo + b;
          sum_hi = sum_hi + sum_lo;
          bytes_left = b;
        end
      end else if (bytes_left != 8'd0) begin
        sum_lo = sum_lo + b;
        sum_hi = sum_hi + sum_lo;
        bytes_left = bytes_left - 8'd1;
      end else if (ofs9 == len9 + FIRST_CHECK_OFS) begin
        if (b != sum_lo) phase = PH_BADCHECK;
      end else if (ofs9 == len9 + SECOND_CHECK_OFS) begin
        phase = (b != sum_hi) ? PH_BADCHECK : PH_OK;
      end
    end

    // A verdict is held back until byte five so that very short chunks
    // always come out as short.
    if (phase != PH_RUN && ofs >= OFS_BYTE_FIVE) begin
      case (phase)
        PH_BADHDR:   st = ST_BADHDR;
        PH_OVERSIZE: st = ST_OVERSIZE;
        PH_BADCHECK: st = ST_BADCHECK;
        default:     st = ST_OK;
      endcase
      close_frame(st, res);
      emitted = 1'b1;
    end else if (beat_last) begin
      close_frame(ST_SHORT, res);
      emitted = 1'b1;
    end else if (ofs != OFS_MAX) begin
      ofs = ofs + 8'd1;
    end
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    logic    produced;
    if (rst) begin
      port_cmd = PORT_COMMAND_RESET;
      phase = PH_IDLE;
      clear_frame();
      verdicts_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) port_cmd = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing actual %h/%b",
                   $time, m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("status", 16'(want.status), 16'(m_tdata[2:0]));
          check_field("command", 16'(want.command), 16'(m_tdata[10:3]));
          check_field("payload_length", 16'(want.payload_length), 16'(m_tdata[18:11]));
          check_field("port", want.port, m_tdata[34:19]);
          check_field("port_valid", 16'(want.port_valid), 16'(m_tuser));
          check_field("tdata padding", 16'h0000, 16'(m_tdata[39:35]));
        end
      end
      if (s_tvalid && s_tready) begin
        advance_frame(s_tdata, s_tuser, s_tlast, produced, fresh);
        if (produced) verdicts_due.push_back(fresh);
      end
    end
    expected_count = verdicts_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fcc_pkg::*;

  localparam int CHUNK_BYTES = CHUNK_BYTES_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tuser = 1'b0;    // [0] chunk_first
  logic        s_tlast = 1'b0;    // chunk_last
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [39:0] m_tdata;           // [2:0] status, [10:3] command,
                                  // [18:11] payload_length, [34:19] port
  logic        m_tuser;           // [0] port_valid

  int fail_count;
  int expected_count;
  int gap_odds = 0;
  int stall_odds = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int items = 0;
  logic [7:0] port_cmd_now = PORT_COMMAND_RESET;
  logic [7:0] frame[$];

  framed_command_checker #(.CHUNK_BYTES(CHUNK_BYTES)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  fcc_frame_monitor #(.CHUNK_BYTES(CHUNK_BYTES)) monitor (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .expected_count(expected_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result-side back-pressure in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left <= $urandom_range(0, 18);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("framed_command_checker: mismatch");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic beat_first,
                           input logic beat_last);
    int gap;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      gap = $urandom_range(1, 19);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= beat_first;
    s_tlast <= beat_last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_chunk(input bit closed);
    for (int i = 0; i < frame.size(); i++)
      send_beat(frame[i], i == 0, closed && (i == frame.size() - 1));
  endtask

  // Well-formed frame with random payload and correct check bytes.
  task automatic build_frame(input logic [7:0] cmd, input logic [7:0] len);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] p;
    frame.delete();
    frame.push_back(HEADER_FIRST);
    frame.push_back(HEADER_SECOND);
    frame.push_back(cmd);
    frame.push_back(len);
    lo = cmd + len;
    hi = cmd + lo;
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom_range(0, 255));
      frame.push_back(p);
      lo = lo + p;
      hi = hi + lo;
    end
    frame.push_back(lo);
    frame.push_back(hi);
  endtask

  function automatic logic [7:0] pick_command();
    return ($urandom_range(0, 1) == 0) ? port_cmd_now : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(0, 8));
    if (r < 8) return 8'($urandom_range(9, CHUNK_BYTES - 7));
    if (r == 8) return 8'(CHUNK_BYTES - 6);
    return 8'(CHUNK_BYTES - 7);
  endfunction

  task automatic write_port_command(input logic [7:0] value);
    s_tvalid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
    // A dropped or ignored beat may still be in the pipeline.
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    port_cmd_now = value;
  endtask

  task automatic run_phase(input int budget);
    int kind;
    int n;
    int stop = items + budget;
    while (items < stop) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        build_frame(pick_command(), pick_length());
        if ($urandom_range(0, 9) < 3) begin
          n = $urandom_range(1, 4);
          repeat (n) frame.push_back(8'($urandom_range(0, 255)));
        end
        items += frame.size();
        send_chunk(1'b1);
      end else if (kind < 63) begin
        build_frame(pick_command(), pick_length());
        n = $urandom_range(0, 2);
        if (n != 1) frame[frame.size() - 2] ^= 8'($urandom_range(1, 255));
        if (n != 0) frame[frame.size() - 1] ^= 8'($urandom_range(1, 255));
        items += frame.size();
        send_chunk(1'b1);
      end else if (kind < 71) begin
        build_frame(pick_command(), pick_length());
        n = $urandom_range(0, 2);
        if (n != 1) frame[0] ^= 8'($urandom_range(1, 255));
        if (n != 0) frame[1] ^= 8'($urandom_range(1, 255));
        items += frame.size();
        send_chunk(1'b1);
      end else if (kind < 78) begin
        frame.delete();
        frame.push_back(HEADER_FIRST);
        frame.push_back(HEADER_SECOND);
        frame.push_back(pick_command());
        n = $urandom_range(0, 3);
        frame.push_back(n == 0 ? 8'(CHUNK_BYTES - 5) :
                        n == 1 ? 8'hFF : 8'($urandom_range(CHUNK_BYTES - 5, 255)));
        n = $urandom_range(0, 6);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
        items += frame.size();
        send_chunk(1'b1);
      end else if (kind < 86) begin
        // Cut before the second check byte, so the chunk ends early.
        build_frame(pick_command(), pick_length());
        n = $urandom_range(1, frame.size() - 1);
        while (frame.size() > n) void'(frame.pop_back());
        items += frame.size();
        send_chunk(1'b1);
      end else if (kind < 92) begin
        // Left open; a later chunk start or closing beat ends it.
        build_frame(pick_command(), pick_length());
        n = $urandom_range(1, frame.size() - 1);
        while (frame.size() > n) void'(frame.pop_back());
        items += frame.size();
        send_chunk(1'b0);
      end else if (kind < 98) begin
        n = $urandom_range(1, 4);
        items += n;
        repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        items++;
      end
    end
    // Close the phase on a complete chunk so the block is idle afterwards.
    build_frame(pick_command(), pick_length());
    items += frame.size();
    send_chunk(1'b1);
  endtask

  initial begin
    logic [7:0] settings[6];
    int gaps[6];
    int stalls[6];
    settings = '{8'h00, 8'hFF, 8'($urandom_range(2, 254)), 8'h80,
                 8'($urandom_range(2, 254)), 8'h01};
    gaps = '{4, 0, 3, 8, 2, 0};
    stalls = '{4, 3, 0, 8, 2, 0};

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Good frame with an empty payload and the reset port command.
    build_frame(PORT_COMMAND_RESET, 8'h00);
    send_chunk(1'b1);
    // Wrong first header byte in a chunk too short for a verdict.
    frame = '{8'h00, HEADER_SECOND};
    send_chunk(1'b1);
    // One-beat chunk.
    frame = '{HEADER_FIRST};
    send_chunk(1'b1);
    // Largest length byte.
    frame = '{HEADER_FIRST, HEADER_SECOND, 8'h7E, 8'hFF, 8'h12, 8'h34};
    send_chunk(1'b1);
    // Beat outside any chunk.
    send_beat(8'hFF, 1'b0, 1'b1);
    // Unfinished chunk dropped by a new start, which carries a bad second check byte.
    frame = '{HEADER_FIRST, HEADER_SECOND, 8'h03};
    send_chunk(1'b0);
    build_frame(8'hFF, 8'h00);
    frame[5] ^= 8'h01;
    send_chunk(1'b1);

    for (int p = 0; p < 6; p++) begin
      write_port_command(settings[p]);
      gap_odds = gaps[p];
      stall_odds = stalls[p];
      run_phase(PHASE_ITEMS);
    end

    s_tvalid <= 1'b0;
    while (expected_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("framed_command_checker: match");
    else
      $display("framed_command_checker: mismatch");
    $finish;
  end

endmodule

// ===== framed_command_checker.f =====
rtl/fcc_pkg.sv
rtl/fcc_in_stage.sv
rtl/fcc_core.sv
rtl/framed_command_checker.sv
sim/fcc_frame_monitor.sv
sim/tb_top.sv
